// ----- hdl/bgrp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgrp_pkg
// Shared types, constants and arithmetic helpers of the BGR to YUV packer.
// ----------------------------------------------------------------------------
package bgrp_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;

	localparam logic [11:0] MAX_W_EFF = 12'(MAX_WIDTH - MAX_WIDTH % 4);
	localparam logic [11:0] MAX_H_EFF = 12'(MAX_HEIGHT - MAX_HEIGHT % 4);

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QLW    = $clog2(QDEPTH + 1);

	// register indexes
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_FORMAT = 2'd2;

	// output layouts
	localparam logic [2:0] FMT_NV21 = 3'd0;
	localparam logic [2:0] FMT_NV12 = 3'd1;
	localparam logic [2:0] FMT_I420 = 3'd2;
	localparam logic [2:0] FMT_YV12 = 3'd3;
	localparam logic [2:0] FMT_YUYV = 3'd4;
	localparam logic [2:0] FMT_UYVY = 3'd5;
	localparam logic [2:0] FMT_444  = 3'd6;

	// Q16 coefficients
	localparam logic [23:0] KY_R = 24'd19595;
	localparam logic [23:0] KY_G = 24'd38470;
	localparam logic [23:0] KY_B = 24'd7471;
	localparam logic [16:0] KU   = 17'd37028;
	localparam logic [16:0] KV   = 17'd46727;
	localparam logic signed [27:0] HALF_Q16 = 28'sd8388608;

	// one pixel's worth of byte writes
	typedef struct packed {
		logic [2:0][23:0] addr;
		logic [2:0][7:0]  val;
		logic [1:0]       cnt;
		logic             fend;
	} write_set_t;

	typedef struct packed {
		logic       valid;
		write_set_t data;
	} push_t;

	function automatic logic [11:0] eff_size(input logic [11:0] r, input logic [11:0] m);
		logic [11:0] v;
		v = {r[11:2], 2'b00};
		if (v < 12'd4) v = 12'd4;
		if (v > m) v = m;
		return v;
	endfunction

	function automatic logic [7:0] chroma_sat(input logic [7:0] comp, input logic [7:0] luma,
		input logic [16:0] k);
		logic signed [9:0]  d;
		logic signed [27:0] t;
		d = signed'({2'b00, comp}) - signed'({2'b00, luma});
		t = 28'(d) * signed'({11'b0, k}) + HALF_Q16;
		if (t[27]) return 8'h00;
		else if (t[26:24] != 3'b000) return 8'hFF;
		else return t[23:16];
	endfunction

endpackage

// ----- hdl/bgrp_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgrp_front
// Config registers, pixel intake, raster counters, color conversion and
// address generation; pushes one write set per pixel into the queue.
// ----------------------------------------------------------------------------
module bgrp_front import bgrp_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_valid,
	input  logic [1:0]     cfg_index,
	input  logic [11:0]    cfg_data,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic [23:0]    s_tdata,
	input  logic [QLW-1:0] q_level,
	output push_t          push
);

	logic [11:0] width_q, height_q;
	logic [2:0]  fmt_q;
	logic [10:0] x_q, y_q;

	logic [11:0] w_eff, h_eff;
	logic        row_end, frame_end, accept;
	logic [QLW:0] in_use;

	logic        v_s1, v_s2;
	logic [7:0]  b_s1, g_s1, r_s1;
	logic [10:0] x_s1, y_s1;
	logic [11:0] w_s1, h_s1;
	logic [2:0]  fmt_s1, fmt_s2;
	logic        fend_s1, fend_s2, ye_s2;
	logic [7:0]  yv_s2, b_s2, r_s2;
	logic [10:0] x_s2;
	logic [22:0] yw_s2, p_s2;

	logic [23:0] ysum;
	logic [23:0] lin, two_i, nv_a, c_off, pl1, pl2;
	logic [7:0]  u_byte, v_byte;
	logic        chroma;
	write_set_t  ws;

	assign w_eff     = eff_size(width_q, MAX_W_EFF);
	assign h_eff     = eff_size(height_q, MAX_H_EFF);
	assign row_end   = ({1'b0, x_q} + 12'd1) >= w_eff;
	assign frame_end = row_end && (({1'b0, y_q} + 12'd1) >= h_eff);

	// credit check: queue slots plus pixels still in the pipeline
	assign in_use   = (QLW+1)'(q_level) + (QLW+1)'(v_s1) + (QLW+1)'(v_s2);
	assign s_tready = in_use < (QLW+1)'(QDEPTH);
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 12'd2048;
			height_q <= 12'd2048;
			fmt_q    <= FMT_YV12;
			x_q      <= '0;
			y_q      <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_WIDTH:  width_q  <= cfg_data;
					REG_HEIGHT: height_q <= cfg_data;
					REG_FORMAT: fmt_q    <= cfg_data[2:0];
					default: ;
				endcase
			end
			if (accept) begin
				if (row_end) begin
					x_q <= '0;
					y_q <= frame_end ? 11'd0 : y_q + 11'd1;
				end else begin
					x_q <= x_q + 11'd1;
				end
			end
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	// stage 1: capture pixel, position and geometry
	always_ff @(posedge clk) begin
		if (accept) begin
			b_s1    <= s_tdata[7:0];
			g_s1    <= s_tdata[15:8];
			r_s1    <= s_tdata[23:16];
			x_s1    <= x_q;
			y_s1    <= y_q;
			w_s1    <= w_eff;
			h_s1    <= h_eff;
			fmt_s1  <= fmt_q;
			fend_s1 <= frame_end;
		end
	end

	assign ysum = 24'(r_s1) * KY_R + 24'(g_s1) * KY_G + 24'(b_s1) * KY_B;

	// stage 2: luma, row offset and plane size
	always_ff @(posedge clk) begin
		yv_s2   <= ysum[23:16];
		b_s2    <= b_s1;
		r_s2    <= r_s1;
		x_s2    <= x_s1;
		ye_s2   <= ~y_s1[0];
		yw_s2   <= 23'(y_s1) * 23'(w_s1);
		p_s2    <= 23'(w_s1) * 23'(h_s1);
		fmt_s2  <= fmt_s1;
		fend_s2 <= fend_s1;
	end

	// chroma and addresses; the 4:2:0 offsets are only used on even rows
	always_comb begin
		u_byte = chroma_sat(b_s2, yv_s2, KU);
		v_byte = chroma_sat(r_s2, yv_s2, KV);
		lin    = 24'(yw_s2) + 24'(x_s2);
		two_i  = {lin[22:0], 1'b0};
		nv_a   = 24'(p_s2) + 24'(yw_s2 >> 1) + 24'(x_s2);
		c_off  = 24'(yw_s2 >> 2) + 24'(x_s2 >> 1);
		pl1    = 24'(p_s2) + c_off;
		pl2    = 24'(p_s2) + 24'(p_s2 >> 2) + c_off;
		chroma = ~x_s2[0] && ye_s2;

		ws.addr[0] = lin;
		ws.val[0]  = yv_s2;
		ws.addr[1] = '0;
		ws.val[1]  = u_byte;
		ws.addr[2] = '0;
		ws.val[2]  = v_byte;
		unique case (fmt_s2)
			FMT_NV21: begin
				ws.addr[1] = nv_a;
				ws.val[1]  = v_byte;
				ws.addr[2] = nv_a + 24'd1;
				ws.val[2]  = u_byte;
			end
			FMT_NV12: begin
				ws.addr[1] = nv_a;
				ws.addr[2] = nv_a + 24'd1;
			end
			FMT_I420: begin
				ws.addr[1] = pl1;
				ws.addr[2] = pl2;
			end
			FMT_YV12: begin
				ws.addr[1] = pl1;
				ws.val[1]  = v_byte;
				ws.addr[2] = pl2;
				ws.val[2]  = u_byte;
			end
			FMT_YUYV: begin
				ws.addr[0] = two_i;
				ws.addr[1] = two_i + 24'd1;
				ws.addr[2] = two_i + 24'd3;
				chroma     = ~x_s2[0];
			end
			FMT_UYVY: begin
				ws.addr[0] = two_i + 24'd1;
				ws.addr[1] = two_i;
				ws.addr[2] = two_i + 24'd2;
				chroma     = ~x_s2[0];
			end
			default: begin
				ws.addr[1] = 24'(p_s2) + lin;
				ws.addr[2] = {p_s2, 1'b0} + lin;
				chroma     = 1'b1;
			end
		endcase
		ws.cnt  = chroma ? 2'd3 : 2'd1;
		ws.fend = fend_s2;
	end

	assign push = {v_s2, ws};

endmodule

// ----- hdl/bgrp_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgrp_queue
// Short FIFO of per-pixel write sets between front and back.
// ----------------------------------------------------------------------------
module bgrp_queue import bgrp_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  push_t          push,
	input  logic           pop,
	output write_set_t     head,
	output logic           not_empty,
	output logic [QLW-1:0] level
);

	write_set_t           slots [QDEPTH];
	logic [QAW-1:0]       wr_ptr_q, rd_ptr_q;
	logic [QLW-1:0]       level_q;

	assign head      = slots[rd_ptr_q];
	assign not_empty = level_q != '0;
	assign level     = level_q;

	always_ff @(posedge clk) begin
		if (push.valid) slots[wr_ptr_q] <= push.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push.valid) wr_ptr_q <= wr_ptr_q + QAW'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + QAW'(1);
			level_q <= level_q + QLW'(push.valid) - QLW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> (level_q < QLW'(QDEPTH) || pop))
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue pop while empty");

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= QLW'(QDEPTH))
		else $error("queue level out of range");

endmodule

// ----- hdl/bgrp_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgrp_back
// Head write set to output register, one byte write per cycle unless stalled.
// ----------------------------------------------------------------------------
module bgrp_back import bgrp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  write_set_t head,
	input  logic       not_empty,
	output logic       pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [31:0] m_tdata,
	output logic       m_tlast,
	output logic       m_tuser
);

	logic [1:0]  idx_q;
	logic        tvalid_q, last_q, fend_q;
	logic [23:0] addr_q;
	logic [7:0]  val_q;
	logic        load, is_last;
	logic [23:0] sel_addr;
	logic [7:0]  sel_val;

	assign load    = not_empty && (!tvalid_q || m_tready);
	assign is_last = idx_q == (head.cnt - 2'd1);
	assign pop     = load && is_last;

	always_comb begin
		unique case (idx_q)
			2'd0: begin
				sel_addr = head.addr[0];
				sel_val  = head.val[0];
			end
			2'd1: begin
				sel_addr = head.addr[1];
				sel_val  = head.val[1];
			end
			default: begin
				sel_addr = head.addr[2];
				sel_val  = head.val[2];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			tvalid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q    <= is_last ? 2'd0 : idx_q + 2'd1;
				tvalid_q <= 1'b1;
			end else if (m_tready) begin
				tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			addr_q <= sel_addr;
			val_q  <= sel_val;
			last_q <= is_last;
			fend_q <= head.fend;
		end
	end

	assign m_tvalid = tvalid_q;
	assign m_tdata  = {val_q, addr_q};
	assign m_tlast  = last_q;
	assign m_tuser  = fend_q;

endmodule

// ----- hdl/bgr_to_yuv_frame_packer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgr_to_yuv_frame_packer
// BGR pixels in raster order to byte writes of a YUV frame buffer layout.
// ----------------------------------------------------------------------------
// Channels: s_* takes one pixel per transfer; m_* gives one byte write per
// transfer (address and value); cfg_* writes width, height and layout.
// A pixel yields one write (Y only) or three (Y then two chroma bytes);
// m_tlast marks the last write of a pixel, m_tuser every write of the
// frame's last pixel.
// A pixel passes the stage 1 and stage 2 registers and a queue slot before
// its first write reaches the output register. The output register issues
// one write per cycle unless the receiver stalls it.
// Pixels are converted in a two-stage pipeline and queued in a four-entry
// write-set FIFO; s_tready drops when queue plus pipeline hold four pixels.
// Reset clears the column and row counters, the queue and the output, and
// loads 2048 x 2048 in YV12. A stalled receiver holds the current write;
// the queue then fills and the input side stalls in turn.
// The user must write configuration only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module bgr_to_yuv_frame_packer import bgrp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,    // blue[7:0], green[15:8], red[23:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,    // byte_address[23:0], byte_value[31:24]
	output logic        m_tlast,
	output logic        m_tuser     // frame_end
);

	push_t          push;
	write_set_t     head;
	logic           not_empty, pop;
	logic [QLW-1:0] level;

	assign cfg_ready = 1'b1;

	bgrp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.q_level   (level),
		.push      (push)
	);

	bgrp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty),
		.level     (level)
	);

	bgrp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.not_empty (not_empty),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

endmodule

// ----- tb/bgr_to_yuv_frame_packer_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgr_to_yuv_frame_packer_checker
// Watches the config, pixel and byte-write channels of the packer. It tracks
// frame size, layout and raster position, works out the byte writes that
// each accepted pixel must cause, and compares every write transfer with the
// oldest one still due.
// ----------------------------------------------------------------------------
module bgr_to_yuv_frame_packer_checker import bgrp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,    // blue[7:0], green[15:8], red[23:16]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,    // byte_address[23:0], byte_value[31:24]
	input  logic        m_tlast,
	input  logic        m_tuser,    // frame_end
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [23:0] addr;
		logic [7:0]  val;
		logic        last_px;
		logic        fend;
	} byte_write_t;

	byte_write_t writes_due[$];
	byte_write_t oldest;

	logic [11:0] frame_w_reg;
	logic [11:0] frame_h_reg;
	logic [2:0]  layout;
	int          col;
	int          row;

	function automatic int fit_size(input logic [11:0] r, input int maxv);
		int v;
		int m;
		v = int'(r) & 'hFFC;
		m = maxv & ~3;
		if (m < 4) m = 4;
		if (v < 4) v = 4;
		if (v > m) v = m;
		return v;
	endfunction

	function automatic logic [7:0] chroma_of(input int diff, input int k);
		int t;
		t = diff * k + 128 * 65536;
		if (t < 0) return 8'h00;
		t = t >>> 16;
		return (t > 255) ? 8'hFF : 8'(t);
	endfunction

	function automatic byte_write_t write_of(input int a, input logic [7:0] v);
		byte_write_t bw;
		bw.addr    = 24'(a);
		bw.val     = v;
		bw.last_px = 1'b0;
		bw.fend    = 1'b0;
		return bw;
	endfunction

	task automatic pack_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r);
		int          w;
		int          h;
		int          p;
		int          i;
		int          a;
		int          c;
		int          luma;
		logic [7:0]  yv;
		logic [7:0]  uv;
		logic [7:0]  vv;
		bit          even_px;
		bit          even_row;
		bit          frame_done;
		byte_write_t burst[$];
		w = fit_size(frame_w_reg, MAX_WIDTH);
		h = fit_size(frame_h_reg, MAX_HEIGHT);
		p = w * h;
		i = row * w + col;
		even_px = (col % 2) == 0;
		even_row = (row % 2) == 0;
		luma = (19595 * int'(r) + 38470 * int'(g) + 7471 * int'(b)) >>> 16;
		yv = 8'(luma);
		uv = chroma_of(int'(b) - luma, 37028);
		vv = chroma_of(int'(r) - luma, 46727);
		case (layout)
			FMT_NV21, FMT_NV12: begin
				burst.push_back(write_of(i, yv));
				if (even_px && even_row) begin
					a = p + (row / 2) * w + col;
					burst.push_back(write_of(a, layout == FMT_NV12 ? uv : vv));
					burst.push_back(write_of(a + 1, layout == FMT_NV12 ? vv : uv));
				end
			end
			FMT_I420, FMT_YV12: begin
				burst.push_back(write_of(i, yv));
				if (even_px && even_row) begin
					c = (row / 2) * (w / 2) + col / 2;
					burst.push_back(write_of(p + c, layout == FMT_I420 ? uv : vv));
					burst.push_back(write_of(p + p / 4 + c, layout == FMT_I420 ? vv : uv));
				end
			end
			FMT_YUYV: begin
				burst.push_back(write_of(2 * i, yv));
				if (even_px) begin
					burst.push_back(write_of(2 * i + 1, uv));
					burst.push_back(write_of(2 * i + 3, vv));
				end
			end
			FMT_UYVY: begin
				burst.push_back(write_of(2 * i + 1, yv));
				if (even_px) begin
					burst.push_back(write_of(2 * i, uv));
					burst.push_back(write_of(2 * i + 2, vv));
				end
			end
			default: begin
				burst.push_back(write_of(i, yv));
				burst.push_back(write_of(p + i, uv));
				burst.push_back(write_of(2 * p + i, vv));
			end
		endcase
		// raster advance; counters left past a shrunken size wrap at once
		frame_done = 1'b0;
		if (col + 1 >= w) begin
			col = 0;
			if (row + 1 >= h) begin
				row = 0;
				frame_done = 1'b1;
			end else begin
				row = row + 1;
			end
		end else begin
			col = col + 1;
		end
		burst[burst.size() - 1].last_px = 1'b1;
		foreach (burst[n]) begin
			burst[n].fend = frame_done;
			writes_due.push_back(burst[n]);
		end
	endtask

	function automatic int check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_w_reg = 12'd2048;
			frame_h_reg = 12'd2048;
			layout = FMT_YV12;
			col = 0;
			row = 0;
			writes_due.delete();
			pending = 0;
			fail_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WIDTH:  frame_w_reg = cfg_data;
					REG_HEIGHT: frame_h_reg = cfg_data;
					REG_FORMAT: layout = cfg_data[2:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				pack_pixel(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]);
			if (m_tvalid && m_tready) begin
				if (writes_due.size() == 0) begin
					$error("unexpected byte write transfer: address %0d value %0d",
						m_tdata[23:0], m_tdata[31:24]);
					fail_count++;
				end else begin
					oldest = writes_due.pop_front();
					fail_count += check_field("byte_address", oldest.addr, m_tdata[23:0]);
					fail_count += check_field("byte_value", oldest.val, m_tdata[31:24]);
					fail_count += check_field("last_of_pixel", oldest.last_px, m_tlast);
					fail_count += check_field("frame_end", oldest.fend, m_tuser);
				end
			end
			pending = writes_due.size();
		end
	end

endmodule

// ----- tb/bgr_to_yuv_frame_packer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgr_to_yuv_frame_packer_tb
// Feeds BGR pixels and layout settings to the packer: a directed opening on
// size clamping, counters left beyond a shrunken frame and the spare layout
// code, then random pixels over small frames in every layout, under three
// idle patterns. A side checker predicts and compares the byte writes.
// ----------------------------------------------------------------------------
module bgr_to_yuv_frame_packer_tb;
	import bgrp_pkg::*;

	localparam logic [1:0] REG_SPARE   = 2'd3;
	localparam logic [2:0] FMT_SPARE   = 3'd7;
	localparam int         QUIET_LIMIT = 2000;
	localparam int         RAND_PHASES = 9;
	localparam int         PHASE_ITEMS = 21;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [11:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;

	int fail_count;
	int pending;
	int send_gap_pct;
	int recv_stall_pct;
	int quiet_cycles;

	bgr_to_yuv_frame_packer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	bgr_to_yuv_frame_packer_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
			(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("bgr_to_yuv_frame_packer_tb: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [7:0] pick_component();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// called just after a falling edge; returns just after the one following
	// the transfer, with tvalid still high
	task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r);
		while ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			s_tdata <= 24'($urandom);
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {r, g, b};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_random_pixel();
		send_pixel(pick_component(), pick_component(), pick_component());
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [11:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_frame(input logic [11:0] w, input logic [11:0] h, input logic [2:0] fmt);
		drain();
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_FORMAT, 12'(fmt));
		cfg_valid <= 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_WIDTH;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		send_gap_pct = 37;
		recv_stall_pct = 67;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// reset layout, full 2048 x 2048 frame
		send_pixel(8'h00, 8'h00, 8'h00);
		send_pixel(8'hFF, 8'hFF, 8'hFF);
		send_pixel(8'hFF, 8'h00, 8'h00);
		send_pixel(8'h00, 8'hFF, 8'h00);
		send_pixel(8'h00, 8'h00, 8'hFF);
		send_pixel(8'h00, 8'hFF, 8'hFF);

		// width clamps up to 4 with the column already past it; height clamps
		// down to the maximum; spare layout code
		set_frame(12'd1, 12'hFFF, FMT_SPARE);
		repeat (14) send_random_pixel();

		// height shrinks below the current row; spare register index
		drain();
		write_reg(REG_WIDTH, 12'd4);
		write_reg(REG_HEIGHT, 12'd0);
		write_reg(REG_FORMAT, 12'(FMT_NV21));
		write_reg(REG_SPARE, 12'hA5A);
		cfg_valid <= 1'b0;
		send_pixel(8'hFF, 8'h00, 8'hFF);
		send_pixel(8'h80, 8'h80, 8'h80);
		send_pixel(8'h01, 8'hFE, 8'h7F);

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			set_frame(12'($urandom_range(20)), 12'($urandom_range(10)), 3'(ph % 8));
			if (ph == 3) begin
				send_gap_pct = 67;
				recv_stall_pct = 37;
			end else if (ph == 6) begin
				send_gap_pct = 0;
				recv_stall_pct = 0;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 4 && n == PHASE_ITEMS / 2) drain();
				send_random_pixel();
			end
		end

		drain();
		repeat (20) @(negedge clk);
		if (fail_count == 0) begin
			$display("bgr_to_yuv_frame_packer_tb: clean");
		end else begin
			$display("bgr_to_yuv_frame_packer_tb: errors");
		end
		$finish;
	end

endmodule
